// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define DQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dq_pkg.sv
// Package with the types, commands and constants of the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int CMD_W    = 3;
  localparam int DQ_DEPTH = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FIRST = 3'd0,
    CMD_PUSH_LAST  = 3'd1,
    CMD_POP_FIRST  = 3'd2,
    CMD_POP_LAST   = 3'd3,
    CMD_SIZE       = 3'd4,
    CMD_EMPTY      = 3'd5,
    CMD_PEEK_FIRST = 3'd6,
    CMD_PEEK_LAST  = 3'd7
  } dq_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
  } dq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     error;
  } dq_rsp_t;

  typedef struct packed {
    logic              push_head;
    logic              pop_head;
    logic              append;
    logic [DATA_W-1:0] word;
  } dq_chain_ctl_t;

endpackage

// File: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
`timescale 1ns / 1ps
// The request channel (req_valid, req_ready, req) carries a command and a word.
// The response channel (rsp_valid, rsp_ready, rsp) returns one word for every
// pop, peek, size and empty command and for a push onto a full queue.
// A successful push returns nothing.
// The queue is held twice in two rows of cells: one keeps the entries from
// front to back and one from back to front, so both ends sit in cell zero.
// A push at an end shifts its row by one cell, and the other row loads the
// word at the cell that the entry count selects.
// A response is registered and shows in the cycle after its command is taken.
// One command is taken per cycle while responses are drained.
// When the receiver stalls, the response holds and req_ready stays low.
// Reset empties the queue and drops any pending response; no clearing pass
// is needed.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = DQ_DEPTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  dq_req_t req,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output dq_rsp_t rsp
);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [DATA_W-1:0] fwd_head;
  logic [DATA_W-1:0] bwd_head;
  dq_chain_ctl_t     fwd_ctl;
  dq_chain_ctl_t     bwd_ctl;
  dq_rsp_t           result;
  logic              emit;
  logic              accept;
  logic              full;
  logic              empty;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    fwd_ctl      = '0;
    bwd_ctl      = '0;
    fwd_ctl.word = req.value;
    bwd_ctl.word = req.value;
    count_next   = count;
    emit         = 1'b0;
    result.data  = '0;
    result.error = 1'b0;
    if (accept) begin
      case (dq_cmd_t'(req.command))
        CMD_PUSH_FIRST: begin
          if (full) begin
            emit         = 1'b1;
            result.error = 1'b1;
          end else begin
            fwd_ctl.push_head = 1'b1;
            bwd_ctl.append    = 1'b1;
            count_next        = count + 1'b1;
          end
        end
        CMD_PUSH_LAST: begin
          if (full) begin
            emit         = 1'b1;
            result.error = 1'b1;
          end else begin
            bwd_ctl.push_head = 1'b1;
            fwd_ctl.append    = 1'b1;
            count_next        = count + 1'b1;
          end
        end
        CMD_POP_FIRST: begin
          emit = 1'b1;
          if (empty) begin
            result.error = 1'b1;
          end else begin
            result.data      = fwd_head;
            fwd_ctl.pop_head = 1'b1;
            count_next       = count - 1'b1;
          end
        end
        CMD_POP_LAST: begin
          emit = 1'b1;
          if (empty) begin
            result.error = 1'b1;
          end else begin
            result.data      = bwd_head;
            bwd_ctl.pop_head = 1'b1;
            count_next       = count - 1'b1;
          end
        end
        CMD_PEEK_FIRST: begin
          emit = 1'b1;
          if (empty) begin
            result.error = 1'b1;
          end else begin
            result.data = fwd_head;
          end
        end
        CMD_PEEK_LAST: begin
          emit = 1'b1;
          if (empty) begin
            result.error = 1'b1;
          end else begin
            result.data = bwd_head;
          end
        end
        CMD_SIZE, CMD_EMPTY: begin
          emit = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    result.count    = COUNT_W'(count_next);
    result.is_empty = (count_next == '0);
  end

  dq_chain #(.DEPTH(DEPTH)) u_fwd_chain (
    .clk   (clk),
    .ctl   (fwd_ctl),
    .count (count),
    .head  (fwd_head)
  );

  dq_chain #(.DEPTH(DEPTH)) u_bwd_chain (
    .clk   (clk),
    .ctl   (bwd_ctl),
    .count (count),
    .head  (bwd_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept && emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      rsp <= result;
    end
  end

endmodule

// File: hw/rtl/dq_cell.sv
// One storage cell of the deque chain, shifting toward either neighbor or loading at the tail.
`timescale 1ns / 1ps
module dq_cell
  import dq_pkg::*;
(
  input  logic              clk,
  input  dq_chain_ctl_t     ctl,
  input  logic              append_here,
  input  logic [DATA_W-1:0] from_lower,
  input  logic [DATA_W-1:0] from_upper,
  output logic [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.push_head) begin
      q <= from_lower;
    end else if (ctl.pop_head) begin
      q <= from_upper;
    end else if (ctl.append && append_here) begin
      q <= ctl.word;
    end
  end

endmodule

// File: hw/rtl/dq_chain.sv
// Row of deque cells holding the entries in order, with the end entry always in cell zero.
`timescale 1ns / 1ps
module dq_chain
  import dq_pkg::*;
#(
  parameter int DEPTH = DQ_DEPTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  dq_chain_ctl_t     ctl,
  input  logic [CW-1:0]     count,
  output logic [DATA_W-1:0] head
);

  logic [DATA_W-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = ctl.word;
    end else begin : g_inner_lo
      assign lower = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner_hi
      assign upper = cell_q[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .append_here (count == CW'(i)),
      .from_lower  (lower),
      .from_upper  (upper),
      .q           (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

// File: hw/rtl/dq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dq_checker
  import dq_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_ready,
  input dq_req_t req,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input dq_rsp_t rsp
);

  logic count_zero;
  logic stalled;

  assign count_zero = (rsp.count == '0);
  assign stalled    = rsp_valid && !rsp_ready;

  `DQ_ASSERT_ALWAYS(a_reset_clears_rsp, clk, rst |=> !rsp_valid, "Response valid after reset.")
  `DQ_ASSERT(a_empty_flag, clk, rst, rsp_valid |-> rsp.is_empty == count_zero, "Bad empty flag.")
  `DQ_ASSERT(a_error_data, clk, rst, rsp_valid && rsp.error |-> rsp.data == '0, "Nonzero error word.")
  `DQ_ASSERT(a_stall_hold, clk, rst, stalled |=> rsp_valid && $stable(rsp), "Stalled word changed.")

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

// File: sim/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed and random traffic.
`timescale 1ns / 1ps
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int AW = $clog2(DQ_DEPTH);
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 300;

  logic    clk;
  logic    rst = 1'b1;
  logic    req_valid = 1'b0;
  logic    req_ready;
  dq_req_t req = '0;
  logic    rsp_valid;
  logic    rsp_ready = 1'b0;
  dq_rsp_t rsp;
  logic    hold_off = 1'b0;

  dq_req_t pending_words[$];
  dq_rsp_t expected_replies[$];
  int unsigned total_words = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int unsigned reply_count = 0;

  logic signed [DATA_W-1:0] mirror_words[DQ_DEPTH];
  logic [AW-1:0]            mirror_head = '0;
  logic [COUNT_W-1:0]       mirror_fill = '0;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void add_word(dq_cmd_t c, logic [DATA_W-1:0] v);
    dq_req_t w;
    w.command = c;
    w.value = v;
    pending_words.insert(pending_words.size(), w);
    total_words++;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Applies one accepted command to the mirror and queues the response it causes.
  task automatic deque_apply(dq_req_t w);
    logic [AW-1:0] slot;
    dq_rsp_t r;
    bit reply;
    r = '0;
    reply = 1'b1;
    case (dq_cmd_t'(w.command))
      CMD_PUSH_FIRST, CMD_PUSH_LAST: begin
        if (mirror_fill == DQ_DEPTH) begin
          r.error = 1'b1;
        end else begin
          reply = 1'b0;
          if (dq_cmd_t'(w.command) == CMD_PUSH_FIRST) begin
            mirror_head = mirror_head - 1'b1;
            slot = mirror_head;
          end else begin
            slot = mirror_head + AW'(mirror_fill);
          end
          mirror_words[slot] = w.value;
          mirror_fill = mirror_fill + 1'b1;
        end
      end
      CMD_SIZE, CMD_EMPTY: begin
      end
      default: begin
        if (mirror_fill == 0) begin
          r.error = 1'b1;
        end else begin
          if (dq_cmd_t'(w.command) == CMD_POP_FIRST || dq_cmd_t'(w.command) == CMD_PEEK_FIRST)
            slot = mirror_head;
          else
            slot = mirror_head + AW'(mirror_fill - 1'b1);
          r.data = mirror_words[slot];
          if (dq_cmd_t'(w.command) == CMD_POP_FIRST) begin
            mirror_head = mirror_head + 1'b1;
            mirror_fill = mirror_fill - 1'b1;
          end else if (dq_cmd_t'(w.command) == CMD_POP_LAST) begin
            mirror_fill = mirror_fill - 1'b1;
          end
        end
      end
    endcase
    r.count = mirror_fill;
    r.is_empty = (mirror_fill == 0);
    if (reply)
      expected_replies.insert(expected_replies.size(), r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (req_valid && req_ready) begin
        deque_apply(req);
        accepted_count++;
        if (accepted_count % 64 == 0)
          send_idle = ($urandom_range(0, 2) != 0);
      end
      if (!req_valid || req_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          req_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          req <= pending_words[0];
          pending_words.delete(0);
          req_valid <= 1'b1;
          send_wait <= send_idle ? $urandom_range(0, 8) : 0;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx
    int unsigned w;
    logic nxt;
    dq_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: data %0d count %0d is_empty %0b error %0b",
                     rsp.data, rsp.count, rsp.is_empty, rsp.error);
        end else begin
          want = expected_replies[0];
          expected_replies.delete(0);
          if (rsp.data !== want.data || rsp.count !== want.count ||
              rsp.is_empty !== want.is_empty || rsp.error !== want.error) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected data %0d count %0d is_empty %0b error %0b,",
                        " got data %0d count %0d is_empty %0b error %0b"},
                       want.data, want.count, want.is_empty, want.error,
                       rsp.data, rsp.count, rsp.is_empty, rsp.error);
          end
        end
        reply_count++;
        if (reply_count % 64 == 0)
          recv_idle = ($urandom_range(0, 2) != 0);
        w = recv_idle ? $urandom_range(0, 8) : 0;
      end
      if (hold_off) begin
        nxt = 1'b0;
      end else if (w != 0) begin
        nxt = 1'b0;
        w = w - 1;
      end else begin
        nxt = 1'b1;
      end
      recv_wait <= w;
      rsp_ready <= nxt;
    end
  end

  // Long receiver stall so that the response register fills and the input stalls.
  initial begin
    wait (accepted_count >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int seg;
    int push_pct;
    int pop_pct;
    int r;
    dq_cmd_t c;

    // Empty queue, both ends, extreme words and wrap of the head below zero.
    add_word(CMD_POP_FIRST, '0);
    add_word(CMD_POP_LAST, '0);
    add_word(CMD_PEEK_FIRST, '0);
    add_word(CMD_PEEK_LAST, '0);
    add_word(CMD_SIZE, '0);
    add_word(CMD_EMPTY, '0);
    add_word(CMD_PUSH_LAST, 32'h7FFF_FFFF);
    add_word(CMD_PUSH_FIRST, 32'h8000_0000);
    add_word(CMD_PUSH_LAST, 32'hFFFF_FFFF);
    add_word(CMD_PUSH_FIRST, 32'h0000_0000);
    add_word(CMD_SIZE, 32'hFFFF_FFFF);
    add_word(CMD_EMPTY, 32'h8000_0000);
    add_word(CMD_PEEK_FIRST, '0);
    add_word(CMD_PEEK_LAST, '0);
    add_word(CMD_POP_LAST, '0);
    add_word(CMD_POP_FIRST, '0);
    add_word(CMD_PEEK_FIRST, '0);
    add_word(CMD_POP_FIRST, '0);
    add_word(CMD_POP_LAST, '0);
    add_word(CMD_EMPTY, '0);
    add_word(CMD_POP_LAST, '0);

    // Random traffic in segments that lean toward pushes or pops.
    for (int s = 0; s < 19; s++) begin
      seg = $urandom_range(0, 2);
      push_pct = (seg == 0) ? 65 : (seg == 1) ? 20 : 40;
      pop_pct  = (seg == 0) ? 15 : (seg == 1) ? 60 : 35;
      for (int i = 0; i < 49; i++) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
          c = $urandom_range(0, 1) ? CMD_PUSH_LAST : CMD_PUSH_FIRST;
        end else if (r < push_pct + pop_pct) begin
          c = $urandom_range(0, 1) ? CMD_POP_LAST : CMD_POP_FIRST;
        end else begin
          case ($urandom_range(0, 3))
            0: c = CMD_SIZE;
            1: c = CMD_EMPTY;
            2: c = CMD_PEEK_FIRST;
            default: c = CMD_PEEK_LAST;
          endcase
        end
        add_word(c, pick_value());
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count != total_words) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && expected_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dq_pkg.sv
hw/rtl/dq_cell.sv
hw/rtl/dq_chain.sv
hw/rtl/double_ended_queue.sv
hw/rtl/dq_checker.sv
sim/tb_double_ended_queue.sv
